// ===== sv/t0_procedure_byte_controller_macros.svh =====
// Assertion macros used by the checker file of the T=0 byte controller.
`ifndef T0_PROCEDURE_BYTE_CONTROLLER_MACROS_SVH
`define T0_PROCEDURE_BYTE_CONTROLLER_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define TPBC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define TPBC_ASSERT_A(name, prop, msg) \
    `TPBC_ASSERT(name, aclk, aresetn, prop, msg)

`endif

// ===== sv/tpbc_pkg.sv =====
// Types, codes and constants of the T=0 procedure byte controller.
package tpbc_pkg;

    localparam int unsigned HEADER_LEN = 5;
    localparam int unsigned RESP_MAX   = 256;

    localparam logic [7:0] HI_MASK    = 8'hF0;
    localparam logic [7:0] HI_SW1_9X  = 8'h90;
    localparam logic [7:0] HI_SW1_6X  = 8'h60;
    localparam logic [7:0] NULL_BYTE  = 8'h60;
    localparam logic [7:0] INV_MASK   = 8'hFF;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_FAIL  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_HEADER   = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_STORE    = 3'd2,
        ACT_FINISHED = 3'd3,
        ACT_FAILED   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CONFLICT = 2'd1,
        ERR_PARITY   = 2'd2,
        ERR_OTHER    = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PROC = 3'd1,
        PH_BULK = 3'd2,
        PH_ONE  = 3'd3,
        PH_SW2  = 3'd4
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ins;
        logic [7:0] p3;
        logic [8:0] command_length;
        logic [7:0] byte_value;
        logic       parity_error;
    } in_item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] start_offset;
        logic [8:0] byte_count;
        logic [7:0] data_out;
        logic [7:0] sw1;
        logic [7:0] sw2;
        logic [8:0] response_length;
        err_t       error_code;
        logic       power_off;
    } out_item_t;

    // Registered input item handed to the engine
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_step_t;

    // Result of one item: valid only when the item causes a result
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_step_t;

endpackage

// ===== sv/tpbc_in_stage.sv =====
// Input register of the T=0 byte controller.
module tpbc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tpbc_pkg::in_item_t  s_item,
    input  logic                advance,
    output tpbc_pkg::in_step_t  step
);

    logic               in_valid_reg;
    logic               in_valid_next;
    tpbc_pkg::in_item_t in_item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    assign step.valid = in_valid_reg;
    assign step.item  = in_item_reg;

endmodule

// ===== sv/tpbc_engine.sv =====
// Command state and procedure byte judgement of the T=0 byte controller.
module tpbc_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpbc_pkg::in_step_t  step,
    input  logic                advance,
    output tpbc_pkg::out_step_t res
);

    localparam logic [8:0] HdrLen  = 9'(tpbc_pkg::HEADER_LEN);
    localparam logic [8:0] RespMax = 9'(tpbc_pkg::RESP_MAX);

    tpbc_pkg::phase_t phase_reg, phase_next;
    logic [7:0] instr_reg, instr_next;
    logic [8:0] exp_reg, exp_next;
    logic       wdir_reg, wdir_next;
    logic [8:0] rcv_reg, rcv_next;
    logic [8:0] sent_reg, sent_next;
    logic [8:0] bulk_reg, bulk_next;
    logic       wasrx_reg, wasrx_next;
    logic [7:0] sw1_reg, sw1_next;

    logic       fire;
    logic [7:0] b;
    logic [3:0] hi;
    logic       is_sw1;
    logic [8:0] rem_send;
    logic [8:0] rem_recv;
    logic [8:0] bulk_dec;
    logic       one_left;
    logic       rsp_full;
    logic       is_write;

    assign fire = step.valid && advance;
    assign b    = step.item.byte_value;
    assign hi   = b[7:4];

    // Procedure byte classes and remaining counts
    assign is_sw1   = ({hi, 4'h0} == tpbc_pkg::HI_SW1_9X)
                   || (({hi, 4'h0} == tpbc_pkg::HI_SW1_6X) && (b != tpbc_pkg::NULL_BYTE));
    assign rem_send = (exp_reg > sent_reg) ? (exp_reg - sent_reg) : 9'd0;
    assign rem_recv = (exp_reg > rcv_reg) ? (exp_reg - rcv_reg) : 9'd0;
    assign bulk_dec = (bulk_reg != 9'd0) ? (bulk_reg - 9'd1) : 9'd0;
    assign one_left = (sent_reg < exp_reg);
    assign rsp_full = (rcv_reg >= RespMax);
    assign is_write = (step.item.command_length > HdrLen);

    // Next state and result of the held item
    always_comb begin
        phase_next = phase_reg;
        instr_next = instr_reg;
        exp_next   = exp_reg;
        wdir_next  = wdir_reg;
        rcv_next   = rcv_reg;
        sent_next  = sent_reg;
        bulk_next  = bulk_reg;
        wasrx_next = wasrx_reg;
        sw1_next   = sw1_reg;
        res        = '0;

        case (step.item.kind)
            tpbc_pkg::KIND_START: begin
                instr_next = step.item.ins;
                wdir_next  = is_write;
                if (is_write) begin
                    exp_next = {1'b0, step.item.p3};
                end else if ((step.item.command_length == 9'd4)
                          || (step.item.p3 == 8'd0)) begin
                    exp_next = RespMax;
                end else begin
                    exp_next = {1'b0, step.item.p3};
                end
                rcv_next              = '0;
                sent_next             = '0;
                bulk_next             = '0;
                wasrx_next            = 1'b0;
                sw1_next              = '0;
                phase_next            = tpbc_pkg::PH_PROC;
                res.valid             = 1'b1;
                res.item.action       = tpbc_pkg::ACT_HEADER;
                res.item.byte_count   = HdrLen;
            end
            tpbc_pkg::KIND_FAIL: begin
                if (phase_reg != tpbc_pkg::PH_IDLE) begin
                    res.valid                = 1'b1;
                    res.item.action          = tpbc_pkg::ACT_FAILED;
                    res.item.response_length = rcv_reg;
                    res.item.error_code      = step.item.parity_error
                                             ? tpbc_pkg::ERR_PARITY : tpbc_pkg::ERR_OTHER;
                    res.item.power_off       = step.item.parity_error && wasrx_reg;
                    phase_next               = tpbc_pkg::PH_IDLE;
                end
            end
            tpbc_pkg::KIND_BYTE: begin
                case (phase_reg)
                    tpbc_pkg::PH_PROC: begin
                        if (b == instr_reg) begin
                            // all remaining data
                            if (wdir_reg) begin
                                res.valid             = 1'b1;
                                res.item.action       = tpbc_pkg::ACT_SEND;
                                res.item.start_offset = sent_reg[7:0];
                                res.item.byte_count   = rem_send;
                                sent_next             = sent_reg + rem_send;
                                wasrx_next            = 1'b0;
                            end else begin
                                wasrx_next = 1'b1;
                                if (rem_recv != 9'd0) begin
                                    bulk_next  = rem_recv;
                                    phase_next = tpbc_pkg::PH_BULK;
                                end
                            end
                        end else if (is_sw1) begin
                            sw1_next   = b;
                            wasrx_next = 1'b1;
                            phase_next = tpbc_pkg::PH_SW2;
                        end else if (b == tpbc_pkg::NULL_BYTE) begin
                            // null byte: keep waiting
                        end else if (b == (instr_reg ^ tpbc_pkg::INV_MASK)) begin
                            // one byte
                            if (wdir_reg) begin
                                res.valid             = 1'b1;
                                res.item.action       = tpbc_pkg::ACT_SEND;
                                res.item.start_offset = sent_reg[7:0];
                                res.item.byte_count   = {8'd0, one_left};
                                sent_next             = sent_reg + {8'd0, one_left};
                                wasrx_next            = 1'b0;
                            end else begin
                                wasrx_next = 1'b1;
                                phase_next = tpbc_pkg::PH_ONE;
                            end
                        end else begin
                            res.valid                = 1'b1;
                            res.item.action          = tpbc_pkg::ACT_FAILED;
                            res.item.response_length = rcv_reg;
                            res.item.error_code      = tpbc_pkg::ERR_CONFLICT;
                            phase_next               = tpbc_pkg::PH_IDLE;
                        end
                    end
                    tpbc_pkg::PH_BULK, tpbc_pkg::PH_ONE: begin
                        if (phase_reg == tpbc_pkg::PH_BULK) begin
                            bulk_next = bulk_dec;
                            if (bulk_dec == 9'd0) begin
                                phase_next = tpbc_pkg::PH_PROC;
                            end
                        end else begin
                            phase_next = tpbc_pkg::PH_PROC;
                        end
                        // store unless the response buffer is full
                        if (!rsp_full) begin
                            res.valid             = 1'b1;
                            res.item.action       = tpbc_pkg::ACT_STORE;
                            res.item.start_offset = rcv_reg[7:0];
                            res.item.data_out     = b;
                            rcv_next              = rcv_reg + 9'd1;
                        end
                    end
                    tpbc_pkg::PH_SW2: begin
                        res.valid                = 1'b1;
                        res.item.action          = tpbc_pkg::ACT_FINISHED;
                        res.item.sw1             = sw1_reg;
                        res.item.sw2             = b;
                        res.item.response_length = rcv_reg + 9'd2;
                        phase_next               = tpbc_pkg::PH_IDLE;
                    end
                    default: begin
                        // idle: card bytes ignored
                    end
                endcase
            end
            default: begin
                // reserved kind: ignored
            end
        endcase

        if (!step.valid) begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tpbc_pkg::PH_IDLE;
            instr_reg <= '0;
            exp_reg   <= '0;
            wdir_reg  <= 1'b0;
            rcv_reg   <= '0;
            sent_reg  <= '0;
            bulk_reg  <= '0;
            wasrx_reg <= 1'b0;
            sw1_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            instr_reg <= instr_next;
            exp_reg   <= exp_next;
            wdir_reg  <= wdir_next;
            rcv_reg   <= rcv_next;
            sent_reg  <= sent_next;
            bulk_reg  <= bulk_next;
            wasrx_reg <= wasrx_next;
            sw1_reg   <= sw1_next;
        end
    end

endmodule

// ===== sv/tpbc_out_stage.sv =====
// Result register of the T=0 byte controller.
module tpbc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpbc_pkg::out_step_t res,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output tpbc_pkg::out_item_t m_item
);

    logic                m_valid_reg;
    logic                m_valid_next;
    tpbc_pkg::out_item_t m_item_reg;

    // Loads when empty or when the held item is taken
    assign advance = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            m_item_reg <= res.item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== sv/t0_procedure_byte_controller.sv =====
// Top level of the T=0 procedure byte controller.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------
//   s_       | in        | s_valid / s_ready  | s_item  (in_item_t)
//   m_       | out       | m_valid / m_ready  | m_item  (out_item_t)
//
// From acceptance an item passes the input register, judgement against the
// command state and the result register.
// One item per cycle is sustained while results are taken; the only loop is
// the state update.
// A stalled result holds the pipeline; the input register still takes
// one item while the result waits.
// Synchronous active-low reset clears the state to idle; no clearing pass.
module t0_procedure_byte_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tpbc_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tpbc_pkg::out_item_t m_item
);

    logic                advance;
    tpbc_pkg::in_step_t  step;
    tpbc_pkg::out_step_t res;

    tpbc_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .advance (advance),
        .step    (step)
    );

    tpbc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .advance (advance),
        .res     (res)
    );

    tpbc_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res     (res),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ===== sv/tpbc_checker.sv =====
// Port checker of the T=0 byte controller, bound to the top level.
`include "t0_procedure_byte_controller_macros.svh"

module tpbc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tpbc_pkg::out_item_t m_item
);

    logic hdr_bad;
    logic poff_bad;

    // Header request must ask for five bytes from offset zero
    assign hdr_bad = (m_item.action == tpbc_pkg::ACT_HEADER)
                  && ((m_item.byte_count != 9'd5) || (m_item.start_offset != 8'd0));

    // Power-off only on a parity failure
    assign poff_bad = m_item.power_off
                   && ((m_item.action != tpbc_pkg::ACT_FAILED)
                    || (m_item.error_code != tpbc_pkg::ERR_PARITY));

    // A waiting result stays offered
    `TPBC_ASSERT_A(a_m_hold, (m_valid && !m_ready) |=> m_valid, "result dropped while stalled")

    // and unchanged
    `TPBC_ASSERT_A(a_m_stable, (m_valid && !m_ready) |=> $stable(m_item), "result changed")

    `TPBC_ASSERT_A(a_header, m_valid |-> !hdr_bad, "bad header request")

    `TPBC_ASSERT_A(a_poweroff, m_valid |-> !poff_bad, "power-off without parity failure")

    // With the result side empty an offered item is always taken
    `TPBC_ASSERT_A(a_s_free, (s_valid && !m_valid) |-> s_ready, "input refused while empty")

endmodule

bind t0_procedure_byte_controller tpbc_checker u_tpbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ===== verif/tb_t0_procedure_byte_controller.sv =====
// Self-checking testbench for the T=0 procedure byte controller.
module tb_t0_procedure_byte_controller;
    import tpbc_pkg::*;

    // Kind code that the block ignores
    localparam kind_t KIND_UNUSED = kind_t'(2'd3);
    localparam int    END_SETTLE  = 20;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Predicted command state
    phase_t     ctl_phase = PH_IDLE;
    logic [7:0] cmd_ins = '0;
    logic [8:0] cmd_len = '0;
    logic       cmd_write = 1'b0;
    logic [8:0] resp_count = '0;
    logic [8:0] data_sent = '0;
    logic [8:0] bulk_left = '0;
    logic       last_rx = 1'b0;
    logic [7:0] sw1_held = '0;

    out_item_t due_actions[$];
    out_item_t want;
    int        mismatches = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        hold_left = 0;
    int        mode_left = 0;
    int        rx_mode = 0;

    t0_procedure_byte_controller dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted action of one accepted item; returns 1 when it causes a result
    function automatic bit card_step(input in_item_t it, output out_item_t res);
        logic [7:0] p3v;
        logic [8:0] rem;
        logic [8:0] cnt;
        res = '0;
        if (it.kind == KIND_START) begin
            cmd_ins = it.ins;
            if (it.command_length > 9'd5) begin
                cmd_write = 1'b1;
                cmd_len = {1'b0, it.p3};
            end else begin
                p3v = (it.command_length == 9'd4) ? 8'd0 : it.p3;
                cmd_write = 1'b0;
                cmd_len = (p3v == 8'd0) ? 9'(RESP_MAX) : {1'b0, p3v};
            end
            resp_count = '0;
            data_sent = '0;
            bulk_left = '0;
            last_rx = 1'b0;
            sw1_held = '0;
            ctl_phase = PH_PROC;
            res.action = ACT_HEADER;
            res.byte_count = 9'(HEADER_LEN);
            return 1'b1;
        end
        if (ctl_phase == PH_IDLE || (it.kind != KIND_BYTE && it.kind != KIND_FAIL))
            return 1'b0;
        // receive failure ends the command in any phase
        if (it.kind == KIND_FAIL) begin
            res.action = ACT_FAILED;
            res.response_length = resp_count;
            res.error_code = it.parity_error ? ERR_PARITY : ERR_OTHER;
            res.power_off = it.parity_error & last_rx;
            ctl_phase = PH_IDLE;
            return 1'b1;
        end
        case (ctl_phase)
            PH_PROC: begin
                if (it.byte_value == cmd_ins) begin
                    if (cmd_write) begin
                        rem = (cmd_len > data_sent) ? cmd_len - data_sent : 9'd0;
                        res.action = ACT_SEND;
                        res.start_offset = data_sent[7:0];
                        res.byte_count = rem;
                        data_sent = data_sent + rem;
                        last_rx = 1'b0;
                        return 1'b1;
                    end
                    rem = (cmd_len > resp_count) ? cmd_len - resp_count : 9'd0;
                    last_rx = 1'b1;
                    if (rem != 9'd0) begin
                        bulk_left = rem;
                        ctl_phase = PH_BULK;
                    end
                    return 1'b0;
                end
                if ((it.byte_value & HI_MASK) == HI_SW1_9X ||
                    ((it.byte_value & HI_MASK) == HI_SW1_6X && it.byte_value != NULL_BYTE)) begin
                    sw1_held = it.byte_value;
                    last_rx = 1'b1;
                    ctl_phase = PH_SW2;
                    return 1'b0;
                end
                if (it.byte_value == NULL_BYTE)
                    return 1'b0;
                if (it.byte_value == (cmd_ins ^ INV_MASK)) begin
                    if (cmd_write) begin
                        cnt = (data_sent < cmd_len) ? 9'd1 : 9'd0;
                        res.action = ACT_SEND;
                        res.start_offset = data_sent[7:0];
                        res.byte_count = cnt;
                        data_sent = data_sent + cnt;
                        last_rx = 1'b0;
                        return 1'b1;
                    end
                    last_rx = 1'b1;
                    ctl_phase = PH_ONE;
                    return 1'b0;
                end
                res.action = ACT_FAILED;
                res.response_length = resp_count;
                res.error_code = ERR_CONFLICT;
                ctl_phase = PH_IDLE;
                return 1'b1;
            end
            PH_BULK, PH_ONE: begin
                if (ctl_phase == PH_ONE) begin
                    ctl_phase = PH_PROC;
                end else begin
                    if (bulk_left > 9'd0)
                        bulk_left = bulk_left - 9'd1;
                    if (bulk_left == 9'd0)
                        ctl_phase = PH_PROC;
                end
                // response buffer full: byte dropped
                if (resp_count >= 9'(RESP_MAX))
                    return 1'b0;
                res.action = ACT_STORE;
                res.start_offset = resp_count[7:0];
                res.data_out = it.byte_value;
                resp_count = resp_count + 9'd1;
                return 1'b1;
            end
            default: begin
                res.action = ACT_FINISHED;
                res.sw1 = sw1_held;
                res.sw2 = it.byte_value;
                res.response_length = resp_count + 9'd2;
                ctl_phase = PH_IDLE;
                return 1'b1;
            end
        endcase
    endfunction

    // Item of the given kind with every other field random
    function automatic in_item_t rand_item(input kind_t k);
        in_item_t it;
        it.kind = k;
        it.ins = 8'($urandom_range(0, 255));
        it.p3 = 8'($urandom_range(0, 255));
        it.command_length = 9'($urandom_range(0, 511));
        it.byte_value = 8'($urandom_range(0, 255));
        it.parity_error = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t start_item(input logic [7:0] ins, input logic [7:0] p3,
                                            input logic [8:0] clen);
        in_item_t it;
        it = rand_item(KIND_START);
        it.ins = ins;
        it.p3 = p3;
        it.command_length = clen;
        return it;
    endfunction

    function automatic in_item_t byte_item(input logic [7:0] b);
        in_item_t it;
        it = rand_item(KIND_BYTE);
        it.byte_value = b;
        return it;
    endfunction

    function automatic in_item_t fail_item(input logic par);
        in_item_t it;
        it = rand_item(KIND_FAIL);
        it.parity_error = par;
        return it;
    endfunction

    // Offers one item from a falling edge, in bursts with random gaps
    task automatic send_item(input in_item_t it);
        out_item_t res;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (card_step(it, res))
            due_actions.push_back(res);
        burst_left--;
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (due_actions.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: long hold-off when asked, otherwise a stall pattern of its own
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            case (rx_mode)
                0: m_ready = 1'b1;
                1: m_ready = 1'($urandom_range(0, 1));
                2: m_ready = ($urandom_range(0, 3) == 0);
                default: m_ready = !m_ready;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [8:0] exp_v,
                               input logic [8:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
        end
    endtask

    // Each result against the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_actions.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item expected none got %h", $time, m_item);
            end else begin
                want = due_actions.pop_front();
                check_field("action", 9'(want.action), 9'(m_item.action));
                check_field("start_offset", 9'(want.start_offset), 9'(m_item.start_offset));
                check_field("byte_count", want.byte_count, m_item.byte_count);
                check_field("data_out", 9'(want.data_out), 9'(m_item.data_out));
                check_field("sw1", 9'(want.sw1), 9'(m_item.sw1));
                check_field("sw2", 9'(want.sw2), 9'(m_item.sw2));
                check_field("response_length", want.response_length,
                            m_item.response_length);
                check_field("error_code", 9'(want.error_code), 9'(m_item.error_code));
                check_field("power_off", 9'(want.power_off), 9'(m_item.power_off));
            end
        end
    end

    // Corner cases of each procedure byte and of the field extremes
    task automatic test_directed();
        send_item(byte_item(8'hAA));                 // idle: ignored
        send_item(fail_item(1'b1));                  // idle: ignored
        send_item(rand_item(KIND_UNUSED));
        send_item(start_item(8'hA4, 8'd3, 9'd8));    // write of three bytes
        send_item(byte_item(NULL_BYTE));
        send_item(byte_item(8'h5B));                 // single byte
        send_item(byte_item(8'hA4));                 // rest
        send_item(byte_item(8'hA4));                 // nothing left: empty range
        send_item(byte_item(8'h5B));                 // single past the end
        send_item(fail_item(1'b1));                  // after a write: no power-off
        send_item(start_item(8'hB0, 8'd2, 9'd5));    // read of two bytes
        send_item(byte_item(8'h4F));
        send_item(byte_item(8'h00));
        send_item(byte_item(8'hB0));
        send_item(byte_item(8'hFF));
        send_item(byte_item(8'hB0));                 // read done: keeps waiting
        send_item(byte_item(8'h61));
        send_item(byte_item(8'h00));
        send_item(start_item(8'hFF, 8'hFF, 9'd4));   // case one, P3 forced to 0
        send_item(byte_item(8'h12));                 // procedure conflict
        send_item(start_item(8'h00, 8'h00, 9'd261));
        send_item(start_item(8'h00, 8'hFF, 9'd3));   // restart while busy, short length
        send_item(byte_item(8'hFF));
        send_item(fail_item(1'b1));                  // parity error while receiving
        send_item(start_item(8'hC0, 8'd1, 9'd0));
        send_item(byte_item(8'h3F));
        send_item(byte_item(8'h90));
        send_item(byte_item(8'h9F));
        send_item(byte_item(8'hFF));
        send_item(start_item(8'h3C, 8'h80, 9'd511));
        send_item(byte_item(8'h3C));
        send_item(fail_item(1'b0));
        wait_drained();
    endtask

    // 256-byte read, then more data once the response buffer is full
    task automatic test_response_full();
        send_item(start_item(8'h20, 8'd0, 9'd5));
        send_item(byte_item(8'h20));
        repeat (256) send_item(byte_item(8'($urandom_range(0, 255))));
        send_item(byte_item(8'hDF));
        send_item(byte_item(8'h5A));                 // dropped
        send_item(byte_item(8'h20));
        send_item(byte_item(8'h90));
        send_item(byte_item(8'h00));
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_left = 100;
        repeat (30) send_item(rand_item(KIND_START));
        wait_drained();
    endtask

    // One well-formed command with random content, broken now and then
    task automatic run_command();
        in_item_t   it;
        int         r;
        int         proc_steps;
        int         total;
        bit         case_one;
        logic [3:0] nib;
        logic [7:0] sw;
        it = rand_item(KIND_START);
        r = $urandom_range(0, 99);
        if (r < 5)
            it.command_length = 9'd4;
        else if (r < 45)
            it.command_length = 9'd5;
        else if (r < 90)
            it.command_length = 9'($urandom_range(6, 261));
        case_one = (it.command_length == 9'd4);
        // most reads short; writes may be any length
        if (!(it.command_length > 9'd5 && $urandom_range(0, 1))) begin
            r = $urandom_range(0, 99);
            it.p3 = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 8));
        end
        send_item(it);
        proc_steps = 0;
        total = 0;
        while (ctl_phase != PH_IDLE) begin
            it = rand_item(KIND_BYTE);
            total++;
            r = $urandom_range(0, 99);
            if (total > 600) begin
                it.kind = KIND_FAIL;
            end else if (ctl_phase != PH_PROC) begin
                if (r < 2)
                    it.kind = KIND_FAIL;
                else if (r < 4)
                    it.kind = KIND_UNUSED;
            end else begin
                proc_steps++;
                if (proc_steps > 12 || (r < 60 && (case_one ||
                        (cmd_write ? data_sent >= cmd_len : resp_count >= cmd_len)))) begin
                    nib = 4'($urandom_range(0, 15));
                    sw = {($urandom_range(0, 1) ? 4'h9 : 4'h6), nib};
                    if (sw == NULL_BYTE)
                        sw = 8'h6A;
                    if (sw == cmd_ins)
                        sw = (sw[7:4] == 4'h9) ? 8'h6B : 8'h9B;
                    it.byte_value = sw;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        it.byte_value = NULL_BYTE;
                    end else if (r < 11) begin
                        it.kind = KIND_FAIL;
                    end else if (r < 14) begin
                        // random byte: mostly a procedure conflict
                    end else if (r < 15) begin
                        it = rand_item(KIND_START);
                        it.p3 = 8'($urandom_range(1, 8));
                        it.command_length = 9'($urandom_range(5, 12));
                    end else if (r < 16) begin
                        it.kind = KIND_UNUSED;
                    end else if (r < 58) begin
                        it.byte_value = cmd_ins;
                    end else begin
                        it.byte_value = cmd_ins ^ INV_MASK;
                    end
                end
            end
            send_item(it);
        end
    endtask

    task automatic test_random();
        int target;
        target = items_sent + 1600;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0)
                send_item(rand_item(kind_t'(2'($urandom_range(0, 3)))));
            else
                run_command();
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_response_full();
        test_backpressure();
        test_random();
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("[t0_procedure_byte_controller] OK");
        else
            $display("[t0_procedure_byte_controller] ERROR");
        $finish;
    end

    // Run limit
    initial begin
        #3000000;
        $display("[t0_procedure_byte_controller] ERROR");
        $finish;
    end

endmodule
